>>> src/assert_macros.svh
// Shared assertion macros. Each one expects clk and rst_n to be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> src/ttu_pkg.sv
package ttu_pkg;

    // Largest number of data bytes one input word can cause, terminator aside.
    localparam int CMD_BYTES = 6;
    localparam int CNT_W     = $clog2(CMD_BYTES + 1);
    localparam int CAP_W     = 9;

    // Depth of the queue between the front and the back.
    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       field_end;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_terminator;
    } result_t;

    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          cnt;
        logic                      term;
    } cmd_t;

endpackage

>>> src/tagged_text_to_utf8_core.sv
// Tagged text to UTF-8 converter.
// Input queue: present one field byte on item with push high; it is taken at
// a clock edge where push is high and full is low. The first byte of a field
// is the encoding code, and field_end marks the last byte of the field.
// Result queue: while empty is low, result holds the oldest UTF-8 byte; pop
// takes it. The last word of every field is a zero byte with is_terminator.
// cfg_write with cfg_data sets the output capacity (terminator included); the
// user must ensure it is written only while no field is in flight; the block
// does not enforce this; it resets to 256. Each byte is combinationally
// decoded into a command of up to six data bytes plus the terminator, which
// goes through a two-entry queue to a serialiser that sends one word per
// cycle while the receiver pops. A byte's command passes the queue and the
// serialiser before its first word is registered at the output. An input
// byte is taken every cycle while the queue has room; the sustained rate is
// set by the serialiser, so bytes that yield many words slow the input. When
// the receiver stops popping, the serialiser and then the queue fill and full
// rises; nothing is lost. Reset empties every stage and starts a new field.
module tagged_text_to_utf8_core
    import ttu_pkg::*;
#(
    parameter int CAPACITY_MAX = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  item_t            item,
    input  logic             pop,
    output logic             empty,
    output result_t          result,
    input  logic             cfg_write,
    input  logic [CAP_W-1:0] cfg_data
);

    logic [CAP_W-1:0] cfg_reg;
    logic [CAP_W-1:0] cap_eff;
    logic             accept;
    logic             cmd_push;
    cmd_t             cmd_in;
    cmd_t             cmd_out;
    logic             cmd_nonempty;
    logic             cmd_take;

    // A capacity of zero acts as one, and values above the maximum are clamped.
    always_comb
    begin
        if (cfg_reg == '0) begin
            cap_eff = CAP_W'(1);
        end
        else if (32'(cfg_reg) > CAPACITY_MAX) begin
            cap_eff = CAP_W'(CAPACITY_MAX);
        end
        else begin
            cap_eff = cfg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= CAP_W'(256);
        end
        else if (cfg_write) begin
            cfg_reg <= cfg_data;
        end
    end

    assign accept = push && !full;

    ttu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cap      (cap_eff),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    ttu_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_data  (cmd_in),
        .full     (full),
        .rd_en    (cmd_take),
        .rd_data  (cmd_out),
        .nonempty (cmd_nonempty)
    );

    ttu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ready (cmd_nonempty),
        .cmd       (cmd_out),
        .cmd_take  (cmd_take),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

>>> src/ttu_front.sv
`include "assert_macros.svh"

module ttu_front
    import ttu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  item_t            item,
    input  logic [CAP_W-1:0] cap,
    output logic             cmd_push,
    output cmd_t             cmd
);

    localparam logic [1:0] PH_ENC  = 2'd0;
    localparam logic [1:0] PH_BOM  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;
    localparam logic [1:0] PH_STOP = 2'd3;

    localparam logic [1:0] KIND_LATIN1    = 2'd0;
    localparam logic [1:0] KIND_UTF16_BOM = 2'd1;
    localparam logic [1:0] KIND_UTF16_BE  = 2'd2;
    localparam logic [1:0] KIND_UTF8      = 2'd3;

    localparam logic [7:0] CODE_LATIN1 = 8'd0;
    localparam logic [7:0] CODE_UTF16  = 8'd1;
    localparam logic [7:0] CODE_UTF8   = 8'd3;

    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          cnt;
        logic [CAP_W-1:0]          bw;
    } acc_t;

    logic [1:0]       phase_reg, phase_next;
    logic [1:0]       kind_reg, kind_next;
    logic             le_reg, le_next;
    logic [7:0]       held_reg, held_next;
    logic             held_valid_reg, held_valid_next;
    logic [9:0]       pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [CAP_W-1:0] bw_reg, bw_next;

    // Appends the UTF-8 form of one character, or drops it when it would not
    // leave room for the terminator. A raw byte is appended as it stands.
    function automatic acc_t add_cp(acc_t a, logic [20:0] cp, logic raw,
                                    logic [CAP_W-1:0] cap_v);
        acc_t       r;
        logic [2:0] n;
        logic [3:0][7:0] e;
        r = a;
        e = '0;
        if (raw || cp < 21'h80) begin
            n    = 3'd1;
            e[0] = cp[7:0];
        end
        else if (cp < 21'h800) begin
            n    = 3'd2;
            e[0] = 8'hC0 | {3'b000, cp[10:6]};
            e[1] = 8'h80 | {2'b00, cp[5:0]};
        end
        else if (cp < 21'h10000) begin
            n    = 3'd3;
            e[0] = 8'hE0 | {4'b0000, cp[15:12]};
            e[1] = 8'h80 | {2'b00, cp[11:6]};
            e[2] = 8'h80 | {2'b00, cp[5:0]};
        end
        else begin
            n    = 3'd4;
            e[0] = 8'hF0 | {5'b00000, cp[20:18]};
            e[1] = 8'h80 | {2'b00, cp[17:12]};
            e[2] = 8'h80 | {2'b00, cp[11:6]};
            e[3] = 8'h80 | {2'b00, cp[5:0]};
        end
        if (({1'b0, a.bw} + {{(CAP_W-2){1'b0}}, n}) < {1'b0, cap_v}) begin
            for (int k = 0; k < 4; k++) begin
                if (3'(k) < n) begin
                    r.bytes[r.cnt] = e[k];
                    r.cnt          = r.cnt + 1'b1;
                end
            end
            r.bw = a.bw + {{(CAP_W-3){1'b0}}, n};
        end
        return r;
    endfunction

    always_comb
    begin
        acc_t        acc;
        logic [15:0] u;
        logic        take;
        logic        term;
        logic [7:0]  b;

        b               = item.in_byte;
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        le_next         = le_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        acc             = '0;
        acc.bw          = bw_reg;
        u               = '0;
        take            = 1'b0;
        term            = 1'b0;

        if (phase_reg == PH_ENC) begin
            le_next         = 1'b0;
            held_next       = '0;
            held_valid_next = 1'b0;
            pend_next       = '0;
            pend_valid_next = 1'b0;
            acc.bw          = '0;
            if (b == CODE_LATIN1) begin
                kind_next = KIND_LATIN1;
            end
            else if (b == CODE_UTF8) begin
                kind_next = KIND_UTF8;
            end
            else if (b == CODE_UTF16) begin
                kind_next = KIND_UTF16_BOM;
            end
            else begin
                kind_next = KIND_UTF16_BE;
            end
            phase_next = (b == CODE_UTF16) ? PH_BOM : PH_BODY;
        end
        else if (phase_reg == PH_STOP) begin
            // Bytes after a stop are ignored until the field ends.
        end
        else if (kind_reg == KIND_LATIN1 || kind_reg == KIND_UTF8) begin
            if (b == 8'd0) begin
                phase_next = PH_STOP;
            end
            else begin
                acc = add_cp(acc, {13'd0, b}, kind_reg == KIND_UTF8, cap);
            end
        end
        else if (!held_valid_reg) begin
            held_next       = b;
            held_valid_next = 1'b1;
        end
        else begin
            u               = le_reg ? {b, held_reg} : {held_reg, b};
            held_valid_next = 1'b0;
            held_next       = '0;
            if (phase_reg == PH_BOM) begin
                phase_next = PH_BODY;
                if (u == 16'hFFFE) begin
                    le_next = 1'b1;
                end
                else if (u != 16'hFEFF) begin
                    take = 1'b1;
                end
            end
            else begin
                take = 1'b1;
            end
        end

        if (take) begin
            if (pend_valid_reg && u >= 16'hDC00 && u < 16'hE000) begin
                // A low surrogate completes the held high one.
                acc = add_cp(acc, 21'h10000 + {1'b0, pend_reg, u[9:0]}, 1'b0, cap);
                pend_valid_next = 1'b0;
                pend_next       = '0;
            end
            else begin
                if (pend_valid_reg) begin
                    acc = add_cp(acc, {5'd0, 6'b110110, pend_reg}, 1'b0, cap);
                end
                pend_valid_next = 1'b0;
                pend_next       = '0;
                if (u == 16'd0) begin
                    phase_next = PH_STOP;
                end
                else if (u >= 16'hD800 && u < 16'hDC00) begin
                    pend_next       = u[9:0];
                    pend_valid_next = 1'b1;
                end
                else begin
                    acc = add_cp(acc, {5'd0, u}, 1'b0, cap);
                end
            end
        end

        if (item.field_end) begin
            if (pend_valid_next) begin
                acc = add_cp(acc, {5'd0, 6'b110110, pend_next}, 1'b0, cap);
            end
            term            = 1'b1;
            phase_next      = PH_ENC;
            kind_next       = KIND_LATIN1;
            le_next         = 1'b0;
            held_next       = '0;
            held_valid_next = 1'b0;
            pend_next       = '0;
            pend_valid_next = 1'b0;
            acc.bw          = '0;
        end

        bw_next   = acc.bw;
        cmd.bytes = acc.bytes;
        cmd.cnt   = acc.cnt;
        cmd.term  = term;
        cmd_push  = accept && (acc.cnt != '0 || term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_ENC;
            kind_reg       <= KIND_LATIN1;
            le_reg         <= 1'b0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            bw_reg         <= '0;
        end
        else if (accept) begin
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            le_reg         <= le_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            bw_reg         <= bw_next;
        end
    end

    `ASSERT_HOLDS(a_field_end_clears, (accept && item.field_end) |=> (phase_reg == PH_ENC && !pend_valid_reg && bw_reg == '0), "field end did not clear the field state")
    `ASSERT_HOLDS(a_pend_only_utf16, pend_valid_reg |-> (kind_reg == KIND_UTF16_BOM || kind_reg == KIND_UTF16_BE), "held surrogate outside a UTF-16 field")

endmodule

>>> src/ttu_cmd_fifo.sv
`include "assert_macros.svh"

module ttu_cmd_fifo
    import ttu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic nonempty
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W_F = $clog2(FIFO_DEPTH + 1);

    cmd_t               mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W_F-1:0] count_reg;

    assign full     = (count_reg == CNT_W_F'(FIFO_DEPTH));
    assign nonempty = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (wr_en) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_no_overflow, wr_en && full, "command written into a full queue")

endmodule

>>> src/ttu_back.sv
`include "assert_macros.svh"

module ttu_back
    import ttu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_ready,
    input  cmd_t    cmd,
    output logic    cmd_take,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    cmd_t             cur_reg;
    logic             cur_valid_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             out_valid_reg;
    result_t          out_reg;

    logic [CNT_W-1:0] total;
    logic             out_free;
    logic             emit;
    logic             last_word;
    logic             is_data;

    // A command gives its data bytes and then, if flagged, the terminator.
    assign total     = cur_reg.cnt + CNT_W'(cur_reg.term);
    assign out_free  = !out_valid_reg || pop;
    assign emit      = cur_valid_reg && out_free;
    assign last_word = emit && (idx_reg == total - 1'b1);
    assign cmd_take  = cmd_ready && (!cur_valid_reg || last_word);
    assign is_data   = idx_reg < cur_reg.cnt;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_take) begin
            cur_reg <= cmd;
        end
        if (emit) begin
            out_reg.out_byte      <= is_data ? cur_reg.bytes[idx_reg] : 8'd0;
            out_reg.is_terminator <= !is_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (cmd_take) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (last_word) begin
                cur_valid_reg <= 1'b0;
            end
            else if (emit) begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (emit) begin
                out_valid_reg <= 1'b1;
            end
            else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `ASSERT_HOLDS(a_cmd_not_empty, cur_valid_reg |-> (total != '0 && cur_reg.cnt <= CNT_W'(CMD_BYTES)), "command with no words or too many bytes")

endmodule
